// File: rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the percentile contrast stretch block.
// ----------------------------------------------------------------------------
package pcs_pkg;

	localparam int unsigned PCT_W        = 7;
	localparam logic [6:0]  PCT_RESET    = 7'd99;
	localparam int unsigned GRAY_W       = 8;
	localparam logic [7:0]  GRAY_MAX     = 8'd255;
	localparam int unsigned PCT_DIV      = 100;

	typedef enum logic {
		KIND_STAT = 1'b0,
		KIND_MAP  = 1'b1
	} kind_t;

endpackage

// File: rtl/core/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// Accepts pixels, updates the histogram and frame statistics, scans and
// clears the histogram at frame end, and queues map pixels for the back end.
// ----------------------------------------------------------------------------
module pcs_front #(
	parameter int unsigned PB  = 12,
	parameter int unsigned CW  = 21,
	parameter int unsigned MAXP = 1048576
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      kind,
	input  logic [PB-1:0]             pixel_value,
	input  logic                      last_in_frame,
	input  logic [pcs_pkg::PCT_W-1:0] percentile,
	input  logic                      q_full,
	output logic                      busy,
	output logic                      q_push,
	output logic [PB-1:0]             q_pixel,
	output logic [PB-1:0]             min_q,
	output logic [PB-1:0]             thr_q
);

	typedef enum logic [2:0] {
		ST_RUN, ST_RD, ST_WR, ST_TGT, ST_SCAN, ST_CLR
	} state_t;

	localparam int unsigned NB = 1 << PB;
	localparam logic [CW-1:0] CMAX = CW'(MAXP);
	localparam int unsigned PW = CW + 7;
	localparam int unsigned RS = PW + $clog2(pcs_pkg::PCT_DIV);
	localparam logic [PW:0] RM = (PW+1)'(((64'd1 << RS) + 64'(pcs_pkg::PCT_DIV) - 64'd1)
		/ 64'(pcs_pkg::PCT_DIV));

	state_t             state_q;
	logic [CW-1:0]      mem [NB];
	logic [CW-1:0]      rd_q;
	logic [PB-1:0]      addr_q;
	logic               last_q;
	logic [CW-1:0]      count_q;
	logic [PB-1:0]      max_q;
	logic [CW+6:0]      prod_q;
	logic [CW+6:0]      target_q;
	logic [CW+6:0]      cum_q;
	logic [PB:0]        idx_q;
	logic               found_q;
	logic               sc_valid_q;
	logic [CW+6:0]      cum_next;
	logic [2*PW:0]      tgt_prod;

	assign busy    = (state_q != ST_RUN) || q_full;
	assign q_push  = start && !busy && (kind == pcs_pkg::KIND_MAP);
	assign q_pixel = pixel_value;
	assign cum_next = cum_q + (CW+7)'(rd_q);
	assign tgt_prod = (2*PW+1)'(prod_q) * (2*PW+1)'(RM);

	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			mem[addr_q] <= (rd_q < CMAX) ? rd_q + 1'b1 : rd_q;
		end else if (state_q == ST_CLR) begin
			mem[idx_q[PB-1:0]] <= '0;
		end
		if (state_q == ST_SCAN) begin
			rd_q <= mem[idx_q[PB-1:0]];
		end else begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			idx_q      <= '0;
			count_q    <= '0;
			min_q      <= '1;
			max_q      <= '0;
			thr_q      <= '0;
			addr_q     <= '0;
			last_q     <= 1'b0;
			prod_q     <= '0;
			target_q   <= '0;
			cum_q      <= '0;
			found_q    <= 1'b0;
			sc_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (start && !busy && kind == pcs_pkg::KIND_STAT) begin
						addr_q <= pixel_value;
						last_q <= last_in_frame;
						if (count_q == '0) begin
							min_q <= pixel_value;
							max_q <= pixel_value;
						end else begin
							if (pixel_value < min_q) min_q <= pixel_value;
							if (pixel_value > max_q) max_q <= pixel_value;
						end
						if (count_q < CMAX) count_q <= count_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (last_q) begin
						prod_q  <= (CW+7)'(count_q) * (CW+7)'(percentile);
						state_q <= ST_TGT;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_TGT: begin
					target_q   <= PW'(tgt_prod >> RS);
					idx_q      <= '0;
					cum_q      <= '0;
					found_q    <= 1'b0;
					sc_valid_q <= 1'b0;
					thr_q      <= max_q;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sc_valid_q) begin
						cum_q <= cum_next;
						if (!found_q && cum_next >= target_q) begin
							found_q <= 1'b1;
							thr_q   <= PB'(idx_q - 1'b1);
						end
					end
					if (idx_q > {1'b0, max_q} || found_q) begin
						idx_q   <= '0;
						state_q <= ST_CLR;
					end else begin
						idx_q      <= idx_q + 1'b1;
						sc_valid_q <= 1'b1;
					end
				end
				ST_CLR: begin
					count_q <= '0;
					if (idx_q == (PB+1)'(NB - 1)) begin
						state_q <= ST_RUN;
					end
					idx_q <= idx_q + 1'b1;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

endmodule

// File: rtl/core/pcs_back.sv
// ----------------------------------------------------------------------------
// pcs_back
// Pops queued map pixels, each with the minimum and threshold in force when
// it was accepted, and computes the stretched gray level with a radix-2
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_back #(
	parameter int unsigned PB = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_push,
	input  logic [PB-1:0]              q_pixel,
	input  logic [PB-1:0]              min_val,
	input  logic [PB-1:0]              thr_val,
	output logic                       q_full,
	output logic                       strobe,
	output logic [pcs_pkg::GRAY_W-1:0] gray,
	output logic [PB-1:0]              threshold
);

	localparam int unsigned NW = PB + 8;
	localparam int unsigned DEPTH = 4;

	typedef enum logic [1:0] { ST_IDLE, ST_DIV, ST_OUT } state_t;

	logic [3*PB-1:0]         fifo_q [DEPTH];
	logic [1:0]              wp_q, rp_q;
	logic [2:0]              cnt_q;
	state_t                  state_q;
	logic [NW-1:0]           num_q;
	logic [NW-1:0]           quo_q;
	logic [NW:0]             rem_q;
	logic [4:0]              bit_q;
	logic                    sat_q;
	logic [PB-1:0]           dthr_q;
	logic [NW:0]             rem_sh;
	logic [PB-1:0]           p_head;
	logic [PB-1:0]           min_head;
	logic [PB-1:0]           thr_head;
	logic [PB-1:0]           diff;
	logic                    pop;

	assign q_full = (cnt_q >= 3'(DEPTH - 1));
	assign {thr_head, min_head, p_head} = fifo_q[rp_q];
	assign diff   = (p_head > min_head) ? p_head - min_head : '0;
	assign pop    = (state_q == ST_IDLE) && (cnt_q != '0);
	assign rem_sh = {rem_q[NW-1:0], num_q[NW-1]};

	always_ff @(posedge clk) begin
		if (q_push) fifo_q[wp_q] <= {thr_val, min_val, q_pixel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			state_q   <= ST_IDLE;
			strobe    <= 1'b0;
			gray      <= '0;
			threshold <= '0;
			num_q     <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			bit_q     <= '0;
			sat_q     <= 1'b0;
			dthr_q    <= '0;
		end else begin
			strobe <= 1'b0;
			if (q_push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 3'(q_push) - 3'(pop);
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						sat_q   <= !(p_head < thr_head);
						dthr_q  <= thr_head;
						num_q   <= NW'(diff) * NW'(pcs_pkg::GRAY_MAX);
						quo_q   <= '0;
						rem_q   <= '0;
						bit_q   <= 5'(NW);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q <= num_q << 1;
					if (rem_sh >= {1'b0, 8'b0, dthr_q}) begin
						rem_q <= rem_sh - (NW+1)'(dthr_q);
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					bit_q <= bit_q - 1'b1;
					if (bit_q == 5'd1) state_q <= ST_OUT;
				end
				ST_OUT: begin
					strobe    <= 1'b1;
					threshold <= dthr_q;
					if (sat_q || quo_q > NW'(pcs_pkg::GRAY_MAX)) gray <= pcs_pkg::GRAY_MAX;
					else gray <= quo_q[7:0];
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/percentile_contrast_stretch.sv
// ----------------------------------------------------------------------------
// percentile_contrast_stretch
// Two-pass histogram percentile contrast stretch for amplitude images.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. Statistics
// pixels (kind 0) give no result and go through the run, read and write
// states of the histogram read-modify-write loop. The frame's last statistics
// pixel adds a target step, a scan of the histogram up to the maximum and a
// clearing pass over all 2^PIXEL_BITS bins.
// Map pixels (kind 1) enter a queue that holds up to three pixels; the back
// end takes one at a time through its idle, divide and output states with its
// bit-serial divider and starts on the next only after the result is out.
// Each result is shown for one cycle with strobe; the receiver cannot stall.
// After reset the histogram is cleared over all bins with busy high;
// percentile resets to 99.
// ----------------------------------------------------------------------------
module percentile_contrast_stretch #(
	parameter int unsigned PIXEL_BITS = 12,
	parameter int unsigned MAX_PIXELS = 1048576
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [PIXEL_BITS-1:0]      pixel_value,
	input  logic                       last_in_frame,
	input  logic                       cfg_we,
	input  logic [pcs_pkg::PCT_W-1:0]  cfg_wdata,
	output logic                       strobe,
	output logic [pcs_pkg::GRAY_W-1:0] gray,
	output logic [PIXEL_BITS-1:0]      threshold
);

	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

	logic [pcs_pkg::PCT_W-1:0] pct_q;
	logic                      q_full, q_push;
	logic [PIXEL_BITS-1:0]     q_pixel, min_v, thr_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pct_q <= pcs_pkg::PCT_RESET;
		else if (cfg_we) pct_q <= cfg_wdata;
	end

	pcs_front #(.PB(PIXEL_BITS), .CW(CW), .MAXP(MAX_PIXELS)) u_front (
		.clk, .arst_n, .start, .kind, .pixel_value, .last_in_frame,
		.percentile(pct_q), .q_full, .busy, .q_push, .q_pixel,
		.min_q(min_v), .thr_q(thr_v)
	);

	pcs_back #(.PB(PIXEL_BITS)) u_back (
		.clk, .arst_n, .q_push, .q_pixel, .min_val(min_v), .thr_val(thr_v),
		.q_full, .strobe, .gray, .threshold
	);

endmodule

// File: rtl/core/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the percentile contrast stretch block.
// ----------------------------------------------------------------------------
module pcs_checker #(
	parameter int unsigned PIXEL_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  strobe,
	input logic                  busy,
	input logic [7:0]            gray,
	input logic [PIXEL_BITS-1:0] threshold
);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe held two cycles");
	a_reset_busy: assert property (@(posedge clk)
		!arst_n |=> busy) else $error("not busy after reset");
	a_zero_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && threshold == '0) |-> gray == 8'd255)
		else $error("zero threshold must clip");

endmodule

bind percentile_contrast_stretch pcs_checker #(.PIXEL_BITS(PIXEL_BITS)) u_chk (
	.clk, .arst_n, .strobe, .busy, .gray, .threshold
);

// File: tb/percentile_contrast_stretch_tb.sv
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_tb
// Self-checking testbench of the percentile contrast stretch block. Statistics
// and map frames are driven through the start/busy handshake, a behavioral
// predictor computes the gray level and threshold of each map pixel, and a
// checker compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module percentile_contrast_stretch_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PIX_BITS  = 12;
	localparam int unsigned NBINS     = 1 << PIX_BITS;
	localparam int unsigned PIX_MAX   = NBINS - 1;
	localparam int unsigned SAT_LIMIT = 1048576;
	localparam int unsigned STALL_LIMIT = 40000;
	localparam int unsigned DRAIN_CYCLES = 64;

	typedef struct {
		logic [pcs_pkg::GRAY_W-1:0] gray;
		logic [PIX_BITS-1:0]        thr;
	} stretch_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       kind = 1'b0;
	logic [PIX_BITS-1:0]        pixel_value = '0;
	logic                       last_in_frame = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [pcs_pkg::PCT_W-1:0]  cfg_wdata = '0;
	logic                       strobe;
	logic [pcs_pkg::GRAY_W-1:0] gray;
	logic [PIX_BITS-1:0]        threshold;

	int unsigned hist_bins[NBINS];
	int unsigned frame_pixels;
	int unsigned lo_value;
	int unsigned hi_value;
	int unsigned cur_thr;
	int unsigned cur_pct;

	stretch_t    pending_gray_q[$];
	int unsigned fail_count;
	int unsigned quiet_cycles;
	int unsigned idle_pct;

	percentile_contrast_stretch #(
		.PIXEL_BITS(PIX_BITS),
		.MAX_PIXELS(SAT_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.pixel_value(pixel_value),
		.last_in_frame(last_in_frame),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.gray(gray),
		.threshold(threshold)
	);

	always #5 clk = ~clk;

	function automatic void pick_threshold();
		longint unsigned target;
		longint unsigned cum;
		int unsigned found;
		target = (longint'(frame_pixels) * longint'(cur_pct)) / pcs_pkg::PCT_DIV;
		cum = 0;
		found = hi_value;
		for (int unsigned b = 0; b <= hi_value; b++) begin
			cum += hist_bins[b];
			if (cum >= target) begin
				found = b;
				break;
			end
		end
		cur_thr = found;
		foreach (hist_bins[i]) hist_bins[i] = 0;
		frame_pixels = 0;
	endfunction

	function automatic void predict_stretch(pcs_pkg::kind_t k, int unsigned p, bit lst);
		stretch_t r;
		int unsigned g;
		int unsigned diff;
		if (k == pcs_pkg::KIND_STAT) begin
			if (frame_pixels == 0) begin
				lo_value = p;
				hi_value = p;
			end else begin
				if (p < lo_value) lo_value = p;
				if (p > hi_value) hi_value = p;
			end
			if (hist_bins[p] < SAT_LIMIT) hist_bins[p]++;
			if (frame_pixels < SAT_LIMIT) frame_pixels++;
			if (lst) pick_threshold();
		end else begin
			g = pcs_pkg::GRAY_MAX;
			if (p < cur_thr) begin
				diff = (p > lo_value) ? p - lo_value : 0;
				g = (diff * 255) / cur_thr;
				if (g > pcs_pkg::GRAY_MAX) g = pcs_pkg::GRAY_MAX;
			end
			r.gray = g[pcs_pkg::GRAY_W-1:0];
			r.thr  = cur_thr[PIX_BITS-1:0];
			pending_gray_q.push_back(r);
		end
	endfunction

	always @(posedge clk) begin
		stretch_t e;
		if (strobe) begin
			if (pending_gray_q.size() == 0) begin
				$error("unexpected result gray=%0d threshold=%0d", gray, threshold);
				fail_count++;
			end else begin
				e = pending_gray_q.pop_front();
				if (gray !== e.gray) begin
					$error("gray: expected %0d, actual %0d", e.gray, gray);
					fail_count++;
				end
				if (threshold !== e.thr) begin
					$error("threshold: expected %0d, actual %0d", e.thr, threshold);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_pixel(pcs_pkg::kind_t k, int unsigned p, bit lst);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start         <= 1'b1;
		kind          <= k;
		pixel_value   <= p[PIX_BITS-1:0];
		last_in_frame <= lst;
		do @(posedge clk); while (busy);
		predict_stretch(k, p, lst);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_gray_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_percentile(int unsigned v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v[pcs_pkg::PCT_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_pct = v;
	endtask

	task automatic run_frame(int unsigned n_stat, int unsigned n_map, int unsigned lo,
			int unsigned hi);
		for (int unsigned i = 0; i < n_stat; i++)
			send_pixel(pcs_pkg::KIND_STAT, $urandom_range(hi, lo), i == n_stat - 1);
		for (int unsigned i = 0; i < n_map; i++)
			send_pixel(pcs_pkg::KIND_MAP, $urandom_range(PIX_MAX, 0), i == n_map - 1);
	endtask

	task automatic test_directed();
		send_pixel(pcs_pkg::KIND_MAP, 0, 1'b0);
		send_pixel(pcs_pkg::KIND_MAP, PIX_MAX, 1'b1);
		send_pixel(pcs_pkg::KIND_STAT, 100, 1'b0);
		send_pixel(pcs_pkg::KIND_STAT, 0, 1'b0);
		send_pixel(pcs_pkg::KIND_STAT, PIX_MAX, 1'b0);
		send_pixel(pcs_pkg::KIND_STAT, 2000, 1'b0);
		send_pixel(pcs_pkg::KIND_STAT, 2000, 1'b1);
		send_pixel(pcs_pkg::KIND_MAP, 0, 1'b0);
		send_pixel(pcs_pkg::KIND_MAP, 1999, 1'b0);
		send_pixel(pcs_pkg::KIND_MAP, 2000, 1'b0);
		send_pixel(pcs_pkg::KIND_MAP, PIX_MAX, 1'b1);
		send_pixel(pcs_pkg::KIND_STAT, 500, 1'b0);
		send_pixel(pcs_pkg::KIND_STAT, 800, 1'b0);
		send_pixel(pcs_pkg::KIND_STAT, 900, 1'b1);
		send_pixel(pcs_pkg::KIND_MAP, 100, 1'b0);
		send_pixel(pcs_pkg::KIND_MAP, 600, 1'b0);
		send_pixel(pcs_pkg::KIND_MAP, 899, 1'b1);
	endtask

	task automatic test_percentile_extremes();
		int unsigned pcts[5] = '{1, 100, 0, 127, 50};
		foreach (pcts[i]) begin
			set_percentile(pcts[i]);
			run_frame(6, 4, 3000, 0);
			send_pixel(pcs_pkg::KIND_STAT, 10, 1'b1);
			send_pixel(pcs_pkg::KIND_MAP, 5, 1'b1);
		end
	endtask

	task automatic test_random();
		int unsigned sent;
		int unsigned ns;
		int unsigned nm;
		int unsigned lo;
		int unsigned hi;
		int unsigned rates[3] = '{38, 85, 0};
		foreach (rates[ph]) begin
			idle_pct = rates[ph];
			set_percentile($urandom_range(100, 1));
			sent = 0;
			while (sent < 260) begin
				if ($urandom_range(9) == 0) begin
					send_pixel(pcs_pkg::kind_t'($urandom_range(1)), $urandom_range(PIX_MAX),
						$urandom_range(1));
					sent++;
				end else begin
					ns = $urandom_range(30, 1);
					nm = $urandom_range(20, 1);
					lo = $urandom_range(PIX_MAX);
					hi = ($urandom_range(1)) ? PIX_MAX : lo + $urandom_range(300);
					if (hi > PIX_MAX) hi = PIX_MAX;
					run_frame(ns, nm, hi, lo);
					sent += ns + nm;
				end
				if ($urandom_range(7) == 0) set_percentile($urandom_range(100, 1));
			end
		end
	endtask

	initial begin
		foreach (hist_bins[i]) hist_bins[i] = 0;
		frame_pixels = 0;
		lo_value = PIX_MAX;
		hi_value = 0;
		cur_thr = 0;
		cur_pct = pcs_pkg::PCT_RESET;
		fail_count = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_percentile_extremes();
		test_random();
		wait_idle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
